FILE: rtl/core/assert_macros.svh
// assertion macros for the rtl files, included by double_ended_queue.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// implication checked on every clock edge outside reset
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// implication with the consequent checked in the next cycle, outside reset
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/deq_pkg.sv
// shared constants and types of the double-ended queue
package deq_pkg;

    localparam int DEPTH_DEF = 1024;
    localparam int WORD_W    = 32;
    localparam int KIND_W    = 3;

    localparam logic [KIND_W-1:0] KIND_QUERY      = 3'd0;
    localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 3'd1;
    localparam logic [KIND_W-1:0] KIND_PUSH_BACK  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_POP_BACK   = 3'd4;

    typedef struct packed {
        logic push_ok;
        logic pop_ok;
        logic at_front;
        logic push_ref;
        logic pop_fail;
        logic need_read;
        logic to_one;
        logic goes_empty;
    } t_step;

endpackage

FILE: rtl/core/deq_ram.sv
// generic single-clock ram, one write port and one registered read port
module deq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/deq_step.sv
// decodes one transaction against the ring pointers: next pointers, count and ram addresses
module deq_step #(
    parameter int DEPTH = deq_pkg::DEPTH_DEF
) (
    input  logic [deq_pkg::KIND_W-1:0]   i_kind,
    input  logic [$clog2(DEPTH)-1:0]     i_head,
    input  logic [$clog2(DEPTH)-1:0]     i_tail,
    input  logic [$clog2(DEPTH+1)-1:0]   i_count,
    output deq_pkg::t_step               o_ctl,
    output logic [$clog2(DEPTH)-1:0]     o_head_nx,
    output logic [$clog2(DEPTH)-1:0]     o_tail_nx,
    output logic [$clog2(DEPTH+1)-1:0]   o_count_nx,
    output logic [$clog2(DEPTH)-1:0]     o_wr_addr,
    output logic [$clog2(DEPTH)-1:0]     o_rd_addr
);
    import deq_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL = CW'(DEPTH);

    logic          is_push_f, is_push_b, is_pop_f, is_pop_b;
    logic          full, empty;
    logic [AW-1:0] head_m1, head_p1, tail_p1, tail_m1, tail_m2;

    assign is_push_f = (i_kind == KIND_PUSH_FRONT);
    assign is_push_b = (i_kind == KIND_PUSH_BACK);
    assign is_pop_f  = (i_kind == KIND_POP_FRONT);
    assign is_pop_b  = (i_kind == KIND_POP_BACK);
    assign full      = (i_count == FULL);
    assign empty     = (i_count == '0);

    assign head_m1 = (i_head == '0)   ? LAST : i_head - 1'b1;
    assign head_p1 = (i_head == LAST) ? '0   : i_head + 1'b1;
    assign tail_p1 = (i_tail == LAST) ? '0   : i_tail + 1'b1;
    assign tail_m1 = (i_tail == '0)   ? LAST : i_tail - 1'b1;
    assign tail_m2 = (tail_m1 == '0)  ? LAST : tail_m1 - 1'b1;

    always_comb begin
        o_ctl            = '0;
        o_ctl.at_front   = is_push_f || is_pop_f;
        o_ctl.push_ok    = (is_push_f || is_push_b) && !full;
        o_ctl.push_ref   = (is_push_f || is_push_b) && full;
        o_ctl.pop_ok     = (is_pop_f || is_pop_b) && !empty;
        o_ctl.pop_fail   = (is_pop_f || is_pop_b) && empty;
        // new end word comes from the ram only when two or more words remain
        o_ctl.need_read  = o_ctl.pop_ok && (i_count > CW'(2));
        o_ctl.to_one     = o_ctl.pop_ok && (i_count == CW'(2));
        o_ctl.goes_empty = o_ctl.pop_ok && (i_count == CW'(1));
    end

    always_comb begin
        o_head_nx  = i_head;
        o_tail_nx  = i_tail;
        o_count_nx = i_count;
        if (o_ctl.push_ok) begin
            o_count_nx = i_count + 1'b1;
            if (is_push_f) begin
                o_head_nx = head_m1;
            end else begin
                o_tail_nx = tail_p1;
            end
        end else if (o_ctl.pop_ok) begin
            o_count_nx = i_count - 1'b1;
            if (is_pop_f) begin
                o_head_nx = head_p1;
            end else begin
                o_tail_nx = tail_m1;
            end
        end
    end

    assign o_wr_addr = is_push_f ? head_m1 : i_tail;
    assign o_rd_addr = is_pop_f  ? head_p1 : tail_m2;

endmodule

FILE: rtl/core/double_ended_queue.sv
// double-ended queue of signed words kept in a ring ram, with cached end words
// Queries, pushes and pops that leave at most one word need no ram read.
// A pop that leaves two or more words passes through the read state: the new
// front or back word is fetched from the ring ram, whose read data is
// registered. The front and back words are held in registers, so pushes
// never read the ram. A new transaction is taken once no ram read is
// outstanding and the result register is empty or its result is being
// taken in the same cycle. No clearing pass after reset.
module double_ended_queue #(
    parameter int DEPTH = deq_pkg::DEPTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [deq_pkg::KIND_W-1:0]          i_kind,
    input  logic signed [deq_pkg::WORD_W-1:0]   i_push_value,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [deq_pkg::WORD_W-1:0]   o_popped_value,
    output logic                                o_pop_failed,
    output logic                                o_push_refused,
    output logic [$clog2(DEPTH+1)-1:0]          o_entry_count,
    output logic                                o_is_empty,
    output logic signed [deq_pkg::WORD_W-1:0]   o_front_word,
    output logic signed [deq_pkg::WORD_W-1:0]   o_back_word
);
    import deq_pkg::*;
    `include "assert_macros.svh"

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic S_IDLE = 1'b0;
    localparam logic S_READ = 1'b1;

    logic                     r_state, n_state;
    logic [AW-1:0]            r_head, r_tail;
    logic [CW-1:0]            r_count;
    logic signed [WORD_W-1:0] r_front, r_back, n_front, n_back;
    logic                     r_rd_front;

    logic                     r_out_valid;
    logic signed [WORD_W-1:0] r_out_popped, r_out_front, r_out_back;
    logic                     r_out_pop_fail, r_out_push_ref;
    logic [CW-1:0]            r_out_count;

    t_step                    step;
    logic [AW-1:0]            head_nx, tail_nx, wr_addr, rd_addr;
    logic [CW-1:0]            count_nx;
    logic [WORD_W-1:0]        rd_data;
    logic                     in_ready, in_acc, out_take;
    logic signed [WORD_W-1:0] popped;

    deq_step #(.DEPTH(DEPTH)) u_step (
        .i_kind     (i_kind),
        .i_head     (r_head),
        .i_tail     (r_tail),
        .i_count    (r_count),
        .o_ctl      (step),
        .o_head_nx  (head_nx),
        .o_tail_nx  (tail_nx),
        .o_count_nx (count_nx),
        .o_wr_addr  (wr_addr),
        .o_rd_addr  (rd_addr)
    );

    deq_ram #(.WIDTH(WORD_W), .DEPTH(DEPTH)) u_ram (
        .i_clk   (i_clk),
        .i_we    (in_acc && step.push_ok),
        .i_waddr (wr_addr),
        .i_wdata (i_push_value),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    assign out_take = r_out_valid && !i_stall;
    assign in_ready = (r_state == S_IDLE) && (!r_out_valid || !i_stall);
    assign in_acc   = i_valid && in_ready;

    // popped word always sits in the front or back cache
    assign popped = !step.pop_ok ? '0 : (step.at_front ? r_front : r_back);

    always_comb begin
        n_front = r_front;
        n_back  = r_back;
        if (step.push_ok) begin
            if (step.at_front) begin
                n_front = i_push_value;
                if (r_count == '0) n_back = i_push_value;
            end else begin
                n_back = i_push_value;
                if (r_count == '0) n_front = i_push_value;
            end
        end else if (step.goes_empty) begin
            n_front = '0;
            n_back  = '0;
        end else if (step.to_one) begin
            if (step.at_front) begin
                n_front = r_back;
            end else begin
                n_back = r_front;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (in_acc && step.need_read) n_state = S_READ;
            S_READ: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_front     <= '0;
            r_back      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (in_acc) begin
                r_head         <= head_nx;
                r_tail         <= tail_nx;
                r_count        <= count_nx;
                r_front        <= n_front;
                r_back         <= n_back;
                r_rd_front     <= step.at_front;
                r_out_popped   <= popped;
                r_out_pop_fail <= step.pop_fail;
                r_out_push_ref <= step.push_ref;
                r_out_count    <= count_nx;
                r_out_front    <= n_front;
                r_out_back     <= n_back;
                // older result is gone: either taken now or never present
                r_out_valid    <= !step.need_read;
            end else if (r_state == S_READ) begin
                // fill in the new end word from the ram
                if (r_rd_front) begin
                    r_front     <= rd_data;
                    r_out_front <= rd_data;
                end else begin
                    r_back     <= rd_data;
                    r_out_back <= rd_data;
                end
                r_out_valid <= 1'b1;
            end else if (out_take) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_stall        = !in_ready;
    assign o_valid        = r_out_valid;
    assign o_popped_value = r_out_popped;
    assign o_pop_failed   = r_out_pop_fail;
    assign o_push_refused = r_out_push_ref;
    assign o_entry_count  = r_out_count;
    assign o_is_empty     = (r_out_count == '0);
    assign o_front_word   = r_out_front;
    assign o_back_word    = r_out_back;

    `ASSERT_CLK(a_count_range, r_count <= CW'(DEPTH), "count exceeds depth")
    `ASSERT_IMPL(a_ptr_meet,
        (r_count == '0) || (r_count == CW'(DEPTH)), r_head == r_tail,
        "pointers disagree with count")
    `ASSERT_IMPL(a_read_out_free, r_state == S_READ, !r_out_valid,
        "result register busy during ram read")
    `ASSERT_NEXT(a_read_follows, in_acc && step.need_read,
        (r_state == S_READ) && !r_out_valid, "pop read not scheduled")

endmodule
